FILE: hdl/cubic_spline_evaluator_unit_assert.svh
// ----------------------------------------------------------------------------
// Cubic spline evaluator assertion macros
// Shared property forms for the concurrent checks of the evaluator.
// ----------------------------------------------------------------------------
`ifndef CUBIC_SPLINE_EVALUATOR_UNIT_ASSERT_SVH
`define CUBIC_SPLINE_EVALUATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define CSEV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSEV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/csev_pkg.sv
// ----------------------------------------------------------------------------
// Cubic spline evaluator package
// Types and fixed widths shared by the front queue and the back engine.
// ----------------------------------------------------------------------------
package csev_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 6;
    localparam int KC_W      = 7;
    localparam int SEG_OUT_W = 6;
    localparam int Q_DEPTH   = 2;
    localparam int QP_W      = $clog2(Q_DEPTH);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               wr_en;
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  key;
        logic [DATA_W-1:0]  ca;
        logic [DATA_W-1:0]  cb;
        logic [DATA_W-1:0]  cc;
        logic [DATA_W-1:0]  cd;
        logic               last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SEEK,
        B_SEEK_CMP,
        B_CHECK,
        B_LOAD,
        B_MUL,
        B_ACC
    } t_bstate;

endpackage

FILE: hdl/csev_front.sv
// ----------------------------------------------------------------------------
// Cubic spline evaluator front end
// Accepts command words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module csev_front #(
    parameter int MAX_KNOTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [csev_pkg::IDX_W-1:0]        i_entry_index,
    input  logic signed [csev_pkg::DATA_W-1:0] i_knot_value,
    input  logic signed [csev_pkg::DATA_W-1:0] i_coef_a,
    input  logic signed [csev_pkg::DATA_W-1:0] i_coef_b,
    input  logic signed [csev_pkg::DATA_W-1:0] i_coef_c,
    input  logic signed [csev_pkg::DATA_W-1:0] i_coef_d,
    input  logic signed [csev_pkg::DATA_W-1:0] i_x_value,
    input  logic                              i_last_point,
    output csev_pkg::t_qhead                  o_head,
    input  logic                              i_pop
);
    import csev_pkg::*;

    t_item           r_q [Q_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QP_W:0]   r_count;
    logic            accept;
    t_item           item;

    assign busy   = (r_count == (QP_W+1)'(Q_DEPTH));
    assign accept = start && !busy;

    always_comb begin
        item.op    = i_cmd ? OP_EVAL : OP_WRITE;
        item.wr_en = (32'(i_entry_index) < 32'(MAX_KNOTS));
        item.idx   = i_entry_index;
        item.key   = i_cmd ? i_x_value : i_knot_value;
        item.ca    = i_coef_a;
        item.cb    = i_coef_b;
        item.cc    = i_coef_c;
        item.cd    = i_coef_d;
        item.last  = i_last_point;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
            case ({accept, i_pop})
                2'b10:   r_count <= r_count + (QP_W+1)'(1);
                2'b01:   r_count <= r_count - (QP_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_q[r_rd_ptr];

endmodule

FILE: hdl/csev_back.sv
// ----------------------------------------------------------------------------
// Cubic spline evaluator back end
// Owns the knot and coefficient tables, walks the segment pointer and runs
// the Horner evaluation on one shared multiplier.
// ----------------------------------------------------------------------------
`include "cubic_spline_evaluator_unit_assert.svh"

module csev_back #(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csev_pkg::t_qhead                    i_head,
    output logic                                o_pop,
    input  logic                                i_cfg_wr,
    input  logic [csev_pkg::KC_W-1:0]           i_cfg_data,
    output logic                                o_strobe,
    output logic signed [csev_pkg::DATA_W-1:0]  o_y_value,
    output logic [csev_pkg::SEG_OUT_W-1:0]      o_segment_used,
    output logic                                o_saturated,
    output logic                                o_run_end
);
    import csev_pkg::*;

    localparam int SEG_W = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
    localparam int CNT_W = $clog2(MAX_KNOTS + 1);
    localparam int LW    = (CNT_W > KC_W) ? CNT_W : KC_W;
    localparam int PW    = 2 * DATA_W + 1;

    logic [DATA_W-1:0] mem_knot [MAX_KNOTS];
    logic [DATA_W-1:0] mem_a    [MAX_KNOTS];
    logic [DATA_W-1:0] mem_b    [MAX_KNOTS];
    logic [DATA_W-1:0] mem_c    [MAX_KNOTS];
    logic [DATA_W-1:0] mem_d    [MAX_KNOTS];

    t_bstate r_state, n_state;

    logic signed [DATA_W-1:0] r_rd_knot, r_rd_a, r_rd_b, r_rd_c, r_rd_d;
    logic [KC_W-1:0]          r_knot_count;
    logic signed [DATA_W-1:0] r_knot0, r_knot1;
    logic [SEG_W-1:0]         r_seg, r_last, r_ptr;
    logic                     r_ptr_valid, r_phase1, r_asc, r_last_pt;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W:0]   r_d;
    logic signed [DATA_W-1:0] r_t, r_ca, r_cb, r_cc;
    logic signed [PW-1:0]     r_prod;
    logic [1:0]               r_stage;
    logic                     r_flag;
    logic                     r_strobe;
    logic signed [DATA_W-1:0] r_y;
    logic [SEG_OUT_W-1:0]     r_seg_out;
    logic                     r_sat_out, r_end_out;

    logic [SEG_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [SEG_W-1:0]         wr_addr;
    logic [LW-1:0]            kc_ext, kc_clamp;
    logic [SEG_W-1:0]         last_c;
    logic                     asc_c, start_eval, beyond;
    logic signed [PW-1:0]     sh;
    logic                     p_ok;
    logic signed [DATA_W-1:0] p_sat, coef_sel, acc;
    logic signed [DATA_W:0]   sum;
    logic                     acc_flag;

    // segment limit from the knot count, clamped to the table
    always_comb begin
        kc_ext = LW'(r_knot_count);
        if (kc_ext < LW'(2)) begin
            kc_clamp = LW'(2);
        end else if (kc_ext > LW'(MAX_KNOTS)) begin
            kc_clamp = LW'(MAX_KNOTS);
        end else begin
            kc_clamp = kc_ext;
        end
        last_c = SEG_W'(kc_clamp - LW'(2));
    end

    assign asc_c      = (r_knot1 >= r_knot0);
    assign start_eval = i_head.valid && (i_head.item.op == OP_EVAL);
    assign beyond     = r_asc ? (r_x >= r_rd_knot) : (r_x <= r_rd_knot);

    // Horner step: floor shift, clip, add coefficient, clip
    always_comb begin
        sh = r_prod >>> FRAC_BITS;
        p_ok = (sh[PW-1:DATA_W-1] == {(PW-DATA_W+1){sh[DATA_W-1]}});
        if (p_ok) begin
            p_sat = sh[DATA_W-1:0];
        end else begin
            p_sat = sh[PW-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        case (r_stage)
            2'd0:    coef_sel = r_cc;
            2'd1:    coef_sel = r_cb;
            default: coef_sel = r_ca;
        endcase
        sum = {coef_sel[DATA_W-1], coef_sel} + {p_sat[DATA_W-1], p_sat};
        if (sum[DATA_W] != sum[DATA_W-1]) begin
            acc = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            acc = sum[DATA_W-1:0];
        end
        acc_flag = !p_ok || (sum[DATA_W] != sum[DATA_W-1]);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (start_eval) begin
                    n_state = B_SEEK;
                end
            end
            B_SEEK: begin
                if (r_seg < r_last) begin
                    n_state = B_SEEK_CMP;
                end else if (r_phase1 && (r_seg != '0)) begin
                    n_state = B_CHECK;
                end else begin
                    n_state = B_LOAD;
                end
            end
            B_SEEK_CMP: begin
                if (beyond) begin
                    n_state = B_SEEK;
                end else if (r_phase1 && (r_seg != '0)) begin
                    n_state = B_CHECK;
                end else begin
                    n_state = B_LOAD;
                end
            end
            B_CHECK: begin
                n_state = beyond ? B_LOAD : B_SEEK;
            end
            B_LOAD:  n_state = B_MUL;
            B_MUL:   n_state = B_ACC;
            B_ACC: begin
                n_state = (r_stage == 2'd2) ? B_IDLE : B_MUL;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = SEG_W'(i_head.item.idx);
        rd_addr = r_seg;
        case (r_state)
            B_IDLE: begin
                o_pop = i_head.valid;
                wr_en = i_head.valid && (i_head.item.op == OP_WRITE) && i_head.item.wr_en;
            end
            B_SEEK: begin
                if (r_seg < r_last) begin
                    rd_addr = r_seg + SEG_W'(1);
                end
            end
            B_SEEK_CMP: begin
                if (beyond) begin
                    rd_addr = r_seg + SEG_W'(1);
                end
            end
            default: rd_addr = r_seg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_knot[wr_addr] <= i_head.item.key;
            mem_a[wr_addr]    <= i_head.item.ca;
            mem_b[wr_addr]    <= i_head.item.cb;
            mem_c[wr_addr]    <= i_head.item.cc;
            mem_d[wr_addr]    <= i_head.item.cd;
        end
        r_rd_knot <= mem_knot[rd_addr];
        r_rd_a    <= mem_a[rd_addr];
        r_rd_b    <= mem_b[rd_addr];
        r_rd_c    <= mem_c[rd_addr];
        r_rd_d    <= mem_d[rd_addr];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (wr_en && (i_head.item.idx == IDX_W'(0))) begin
            r_knot0 <= i_head.item.key;
        end
        if (wr_en && (i_head.item.idx == IDX_W'(1))) begin
            r_knot1 <= i_head.item.key;
        end
        case (r_state)
            B_IDLE: begin
                r_x       <= i_head.item.key;
                r_last_pt <= i_head.item.last;
                r_last    <= last_c;
                r_asc     <= asc_c;
                r_phase1  <= r_ptr_valid && (r_ptr <= last_c);
                r_seg     <= (r_ptr_valid && (r_ptr <= last_c)) ? r_ptr : '0;
            end
            B_SEEK_CMP: begin
                if (beyond) begin
                    r_seg <= r_seg + SEG_W'(1);
                end
            end
            B_CHECK: begin
                if (!beyond) begin
                    r_seg    <= '0;
                    r_phase1 <= 1'b0;
                end
            end
            B_LOAD: begin
                r_d  <= {r_x[DATA_W-1], r_x} - {r_rd_knot[DATA_W-1], r_rd_knot};
                r_t  <= r_rd_d;
                r_ca <= r_rd_a;
                r_cb <= r_rd_b;
                r_cc <= r_rd_c;
            end
            B_MUL: begin
                r_prod <= PW'(r_d * r_t);
            end
            B_ACC: begin
                r_t <= acc;
            end
            default: r_t <= r_t;
        endcase
        if (r_state == B_ACC && r_stage == 2'd2) begin
            r_y       <= acc;
            r_seg_out <= SEG_OUT_W'(r_seg);
            r_sat_out <= r_flag || acc_flag;
            r_end_out <= r_last_pt;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_knot_count <= KC_W'(2);
            r_ptr        <= '0;
            r_ptr_valid  <= 1'b0;
            r_stage      <= 2'd0;
            r_flag       <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == B_ACC) && (r_stage == 2'd2);
            if (i_cfg_wr) begin
                r_knot_count <= i_cfg_data;
                r_ptr        <= '0;
                r_ptr_valid  <= 1'b0;
            end
            if (wr_en || (o_pop && (i_head.item.op == OP_WRITE))) begin
                r_ptr       <= '0;
                r_ptr_valid <= 1'b0;
            end
            case (r_state)
                B_LOAD: begin
                    r_stage <= 2'd0;
                    r_flag  <= 1'b0;
                end
                B_ACC: begin
                    r_flag  <= r_flag || acc_flag;
                    r_stage <= (r_stage == 2'd2) ? 2'd0 : r_stage + 2'd1;
                    if (r_stage == 2'd2) begin
                        r_ptr       <= r_last_pt ? '0 : r_seg;
                        r_ptr_valid <= !r_last_pt;
                    end
                end
                default: r_stage <= r_stage;
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_y_value      = r_y;
    assign o_segment_used = r_seg_out;
    assign o_saturated    = r_sat_out;
    assign o_run_end      = r_end_out;

    `CSEV_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, r_strobe, !r_strobe, "strobe repeated")
    `CSEV_ASSERT_IMP(a_pop_valid, i_clk, i_rst_n, o_pop, i_head.valid, "pop from empty queue")
    `CSEV_ASSERT_IMP(a_seek_range, i_clk, i_rst_n, r_state == B_SEEK_CMP, r_seg < r_last, "seek past last segment")
    `CSEV_ASSERT_IMP(a_seg_range, i_clk, i_rst_n, r_state == B_LOAD, r_seg <= r_last, "segment beyond table")

endmodule

FILE: hdl/cubic_spline_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Cubic spline evaluator unit
// Piecewise cubic evaluation over a loaded knot and coefficient table.
// ----------------------------------------------------------------------------
// Usage:
//   Command words enter when start is high and busy is low. cmd = 0 writes
//   one table entry (knot and four coefficients); cmd = 1 evaluates x_value.
//   A two-word queue parts the front end from the evaluation engine, so busy
//   rises only when both queue slots are taken.
//   Each evaluation returns one word on the result ports for one cycle,
//   marked by o_strobe; writes return nothing. The receiver cannot stall.
//   An evaluation searches for its segment from the kept pointer or from
//   segment 0. A search that starts from a kept pointer above segment 0
//   adds a check, and a failed check restarts the search from segment 0.
//   Each search step waits on the registered table read port, and the
//   Horner part is three passes through one multiplier.
//   Configuration writes the knot count on its own channel, always ready;
//   the user must write it only while the unit is idle (not enforced).
//   Reset empties the queue, sets the knot count to 2 and drops the segment
//   pointer; table contents are undefined until written.
// ----------------------------------------------------------------------------
module cubic_spline_evaluator_unit #(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic [csev_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [csev_pkg::DATA_W-1:0]  i_knot_value,
    input  logic signed [csev_pkg::DATA_W-1:0]  i_coef_a,
    input  logic signed [csev_pkg::DATA_W-1:0]  i_coef_b,
    input  logic signed [csev_pkg::DATA_W-1:0]  i_coef_c,
    input  logic signed [csev_pkg::DATA_W-1:0]  i_coef_d,
    input  logic signed [csev_pkg::DATA_W-1:0]  i_x_value,
    input  logic                                i_last_point,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [csev_pkg::KC_W-1:0]           i_cfg_data,
    output logic                                o_strobe,
    output logic signed [csev_pkg::DATA_W-1:0]  o_y_value,
    output logic [csev_pkg::SEG_OUT_W-1:0]      o_segment_used,
    output logic                                o_saturated,
    output logic                                o_run_end
);
    import csev_pkg::*;

    t_qhead head;
    logic   pop;

    assign o_cfg_ready = 1'b1;

    csev_front #(
        .MAX_KNOTS (MAX_KNOTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_entry_index (i_entry_index),
        .i_knot_value  (i_knot_value),
        .i_coef_a      (i_coef_a),
        .i_coef_b      (i_coef_b),
        .i_coef_c      (i_coef_c),
        .i_coef_d      (i_coef_d),
        .i_x_value     (i_x_value),
        .i_last_point  (i_last_point),
        .o_head        (head),
        .i_pop         (pop)
    );

    csev_back #(
        .MAX_KNOTS (MAX_KNOTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_y_value      (o_y_value),
        .o_segment_used (o_segment_used),
        .o_saturated    (o_saturated),
        .o_run_end      (o_run_end)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic spline evaluator testbench
// Loads knot and coefficient tables, sweeps point runs across them and checks
// every result word against a pinned word or a predictor kept in step with
// the table, knot count and segment pointer, under several sender idle rates.
// ----------------------------------------------------------------------------
module tb;
    import csev_pkg::*;

    localparam int          TAB_DEPTH   = 64;
    localparam int          FRAC        = 16;
    localparam int          ONE         = 65536;
    localparam int          DRAIN_CYC   = 160;
    localparam int          PHASE_WORDS = 12;
    localparam int          CYCLE_LIMIT = 700000;
    localparam longint      LMAX        = 2147483647;
    localparam longint      LMIN        = -longint'(2147483647) - 1;
    localparam logic [31:0] Q_ONE       = 32'h0001_0000;
    localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN       = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] y;
        logic [5:0]  seg;
        logic        sat;
        logic        run_end;
    } spline_res_t;

    typedef struct {
        bit          is_cfg;
        logic [6:0]  kc;
        t_op         op;
        logic [5:0]  idx;
        logic [31:0] knot;
        logic [31:0] ca;
        logic [31:0] cb;
        logic [31:0] cc;
        logic [31:0] cd;
        logic [31:0] x;
        logic        last;
        bit          pin;
        spline_res_t res;
    } plan_row_t;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_cmd;
    logic [IDX_W-1:0]          i_entry_index;
    logic signed [DATA_W-1:0]  i_knot_value;
    logic signed [DATA_W-1:0]  i_coef_a;
    logic signed [DATA_W-1:0]  i_coef_b;
    logic signed [DATA_W-1:0]  i_coef_c;
    logic signed [DATA_W-1:0]  i_coef_d;
    logic signed [DATA_W-1:0]  i_x_value;
    logic                      i_last_point;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [KC_W-1:0]           i_cfg_data;
    logic                      o_strobe;
    logic signed [DATA_W-1:0]  o_y_value;
    logic [SEG_OUT_W-1:0]      o_segment_used;
    logic                      o_saturated;
    logic                      o_run_end;

    bit                        pinned_on;
    spline_res_t               pinned_res;

    longint                    knot_tab   [TAB_DEPTH];
    longint                    coef_a_tab [TAB_DEPTH];
    longint                    coef_b_tab [TAB_DEPTH];
    longint                    coef_c_tab [TAB_DEPTH];
    longint                    coef_d_tab [TAB_DEPTH];
    int unsigned               seg_ptr;
    bit                        ptr_valid;
    logic [6:0]                knot_count_reg;

    spline_res_t               pending_results [$];
    plan_row_t                 plan [$];
    int                        fail_count;
    int                        evals_checked;
    int                        writes_seen;
    int                        cfg_writes;
    int                        sat_seen;
    int                        cycle_count;

    int                        idle_pct;
    int                        run_dir;
    longint                    tab_first;
    longint                    tab_last;

    logic [6:0]                kc_plan   [11] = '{7'd3, 7'd127, 7'd2, 7'd6, 7'd0, 7'd64,
                                                 7'd9, 7'd1, 7'd17, 7'd65, 7'd4};
    int                        idle_plan [3]  = '{0, 77, 15};

    cubic_spline_evaluator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_entry_index  (i_entry_index),
        .i_knot_value   (i_knot_value),
        .i_coef_a       (i_coef_a),
        .i_coef_b       (i_coef_b),
        .i_coef_c       (i_coef_c),
        .i_coef_d       (i_coef_d),
        .i_x_value      (i_x_value),
        .i_last_point   (i_last_point),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_y_value      (o_y_value),
        .o_segment_used (o_segment_used),
        .o_saturated    (o_saturated),
        .o_run_end      (o_run_end)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int unsigned eff_knots(logic [6:0] kc);
        if (kc < 2)
            return 2;
        if (kc > TAB_DEPTH)
            return TAB_DEPTH;
        return kc;
    endfunction

    function automatic logic [31:0] to_q(longint v);
        if (v > LMAX)
            return Q_MAX;
        if (v < LMIN)
            return Q_MIN;
        return v[31:0];
    endfunction

    function automatic longint clip32(longint v, inout bit clipped);
        if (v > LMAX) begin
            clipped = 1'b1;
            return LMAX;
        end
        if (v < LMIN) begin
            clipped = 1'b1;
            return LMIN;
        end
        return v;
    endfunction

    function automatic longint qmul(longint d, longint t, inout bit clipped);
        return clip32((d * t) >>> FRAC, clipped);
    endfunction

    function automatic bit beyond(longint x, longint k, bit asc);
        return asc ? (x >= k) : (x <= k);
    endfunction

    function automatic int unsigned seek_segment(int unsigned from, int unsigned last_seg,
                                                 longint x, bit asc);
        int unsigned seg;
        seg = from;
        while (seg < last_seg && beyond(x, knot_tab[seg + 1], asc))
            seg++;
        return seg;
    endfunction

    function automatic void table_store(logic [5:0] idx, logic signed [31:0] k,
                                        logic signed [31:0] a, logic signed [31:0] b,
                                        logic signed [31:0] c, logic signed [31:0] d);
        knot_tab[idx]   = longint'(k);
        coef_a_tab[idx] = longint'(a);
        coef_b_tab[idx] = longint'(b);
        coef_c_tab[idx] = longint'(c);
        coef_d_tab[idx] = longint'(d);
        seg_ptr         = 0;
        ptr_valid       = 1'b0;
    endfunction

    function automatic spline_res_t spline_eval(logic signed [31:0] xin, logic last_in);
        int unsigned last_seg;
        int unsigned seg;
        bit          asc;
        bit          clipped;
        longint      x;
        longint      d;
        longint      t;
        spline_res_t r;
        last_seg = eff_knots(knot_count_reg) - 2;
        asc      = knot_tab[1] >= knot_tab[0];
        x        = longint'(xin);
        clipped  = 1'b0;
        if (ptr_valid && seg_ptr <= last_seg) begin
            seg = seek_segment(seg_ptr, last_seg, x, asc);
            if (seg > 0 && !beyond(x, knot_tab[seg], asc))
                seg = seek_segment(0, last_seg, x, asc);
        end else begin
            seg = seek_segment(0, last_seg, x, asc);
        end
        d = x - knot_tab[seg];
        t = clip32(coef_c_tab[seg] + qmul(d, coef_d_tab[seg], clipped), clipped);
        t = clip32(coef_b_tab[seg] + qmul(d, t, clipped), clipped);
        t = clip32(coef_a_tab[seg] + qmul(d, t, clipped), clipped);
        if (last_in) begin
            seg_ptr   = 0;
            ptr_valid = 1'b0;
        end else begin
            seg_ptr   = seg;
            ptr_valid = 1'b1;
        end
        r.y       = t[31:0];
        r.seg     = seg[5:0];
        r.sat     = clipped;
        r.run_end = last_in;
        return r;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        spline_res_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d results pending", $time,
                     pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result word, expected none, actual y=%h seg=%0d",
                             $time, o_y_value, o_segment_used);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("y_value", want.y, o_y_value);
                    compare_field("segment_used", 32'(want.seg), 32'(o_segment_used));
                    compare_field("saturated", 32'(want.sat), 32'(o_saturated));
                    compare_field("run_end", 32'(want.run_end), 32'(o_run_end));
                    evals_checked++;
                    if (want.sat)
                        sat_seen++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                knot_count_reg = i_cfg_data;
                seg_ptr        = 0;
                ptr_valid      = 1'b0;
                cfg_writes++;
            end
            if (start && !busy) begin
                if (t_op'(i_cmd) == OP_WRITE) begin
                    table_store(i_entry_index, i_knot_value, i_coef_a, i_coef_b,
                                i_coef_c, i_coef_d);
                    writes_seen++;
                end else begin
                    want = spline_eval(i_x_value, i_last_point);
                    if (pinned_on)
                        want = pinned_res;
                    pending_results.push_back(want);
                end
            end
        end
    end

    function automatic logic [31:0] rand_coef();
        if ($urandom_range(1))
            return $urandom();
        return to_q(longint'($urandom_range(0, 8 * ONE)) - 4 * ONE);
    endfunction

    function automatic void plan_write(logic [5:0] idx, logic [31:0] k, logic [31:0] a,
                                       logic [31:0] b, logic [31:0] c, logic [31:0] d);
        plan_row_t r;
        r        = '{op: OP_WRITE, default: '0};
        r.op     = OP_WRITE;
        r.idx    = idx;
        r.knot   = k;
        r.ca     = a;
        r.cb     = b;
        r.cc     = c;
        r.cd     = d;
        plan.push_back(r);
    endfunction

    function automatic void plan_eval(logic [31:0] x, logic last, bit pin,
                                      logic [31:0] y, logic sat);
        plan_row_t r;
        r             = '{op: OP_EVAL, default: '0};
        r.op          = OP_EVAL;
        r.x           = x;
        r.last        = last;
        r.pin         = pin;
        r.res.y       = y;
        r.res.seg     = '0;
        r.res.sat     = sat;
        r.res.run_end = last;
        plan.push_back(r);
    endfunction

    function automatic void plan_cfg(logic [6:0] kc);
        plan_row_t r;
        r        = '{op: OP_WRITE, default: '0};
        r.op     = OP_WRITE;
        r.is_cfg = 1'b1;
        r.kc     = kc;
        plan.push_back(r);
    endfunction

    task automatic send_word(t_op op, logic [5:0] idx, logic [31:0] k, logic [31:0] a,
                             logic [31:0] b, logic [31:0] c, logic [31:0] d,
                             logic [31:0] x, logic last, bit pin, spline_res_t pres);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start         <= 1'b1;
        i_cmd         <= op;
        i_entry_index <= idx;
        i_knot_value  <= k;
        i_coef_a      <= a;
        i_coef_b      <= b;
        i_coef_c      <= c;
        i_coef_d      <= d;
        i_x_value     <= x;
        i_last_point  <= last;
        pinned_on     <= pin;
        pinned_res    <= pres;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_eval(longint xv, logic last);
        send_word(OP_EVAL, 6'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), to_q(xv), last, 1'b0, '0);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_knot_count(logic [6:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_table(int unsigned n);
        int     mode;
        longint k;
        longint step;
        mode = $urandom_range(5);
        k    = longint'($urandom_range(0, 32 * ONE)) - 16 * ONE;
        for (int unsigned i = 0; i < n; i++) begin
            if (mode == 5)
                k = longint'($signed($urandom()));
            send_word(OP_WRITE, i[5:0], to_q(k), rand_coef(), rand_coef(), rand_coef(),
                      rand_coef(), $urandom(), 1'($urandom()), 1'b0, '0);
            if (i == 0)
                tab_first = k;
            tab_last = k;
            step = ($urandom_range(7) == 0) ? 0 : longint'($urandom_range(1, 4 * ONE));
            k    = (mode < 3) ? k + step : k - step;
        end
        run_dir = (tab_last >= tab_first) ? 1 : -1;
    endtask

    task automatic random_words();
        int unsigned n_words;
        int unsigned span;
        int unsigned len;
        longint      lo;
        longint      xv;
        lo      = (tab_first < tab_last) ? tab_first : tab_last;
        xv      = (tab_first < tab_last) ? tab_last - tab_first : tab_first - tab_last;
        span    = (xv + ONE > LMAX) ? 32'h7FFF_FFFF : 32'(xv + ONE);
        n_words = 0;
        while (n_words < PHASE_WORDS) begin
            case ($urandom_range(9))
                0: begin
                    send_word(OP_WRITE, 6'($urandom()), $urandom(), rand_coef(), rand_coef(),
                              rand_coef(), rand_coef(), $urandom(), 1'($urandom()),
                              1'b0, '0);
                    n_words++;
                end
                1: begin
                    send_eval(longint'($signed($urandom())), 1'($urandom()));
                    n_words++;
                end
                default: begin
                    len = $urandom_range(1, 8);
                    xv  = tab_first - run_dir * longint'($urandom_range(0, span / 8));
                    for (int unsigned j = 0; j < len; j++) begin
                        if ($urandom_range(9) == 0)
                            xv = lo + longint'($urandom_range(0, span));
                        send_eval(xv, j == len - 1);
                        xv += run_dir * longint'($urandom_range(0, span / 3));
                        n_words++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = 1'b0;
        i_entry_index  = '0;
        i_knot_value   = '0;
        i_coef_a       = '0;
        i_coef_b       = '0;
        i_coef_c       = '0;
        i_coef_d       = '0;
        i_x_value      = '0;
        i_last_point   = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        pinned_on      = 1'b0;
        pinned_res     = '0;
        fail_count     = 0;
        evals_checked  = 0;
        writes_seen    = 0;
        cfg_writes     = 0;
        sat_seen       = 0;
        cycle_count    = 0;
        idle_pct       = 0;
        run_dir        = 1;
        tab_first      = 0;
        tab_last       = 0;
        seg_ptr        = 0;
        ptr_valid      = 1'b0;
        knot_count_reg = 7'd2;
        foreach (knot_tab[i]) begin
            knot_tab[i]   = 0;
            coef_a_tab[i] = 0;
            coef_b_tab[i] = 0;
            coef_c_tab[i] = 0;
            coef_d_tab[i] = 0;
        end

        plan_write(6'd0, 32'h0, Q_ONE, 32'h0, 32'h0, 32'h0);
        plan_write(6'd1, Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0);
        plan_eval(32'h0, 1'b0, 1'b1, Q_ONE, 1'b0);
        plan_write(6'd0, Q_MIN, Q_MAX, Q_MAX, 32'h0, 32'h0);
        plan_write(6'd1, Q_MAX, 32'h0, 32'h0, 32'h0, 32'h0);
        plan_eval(Q_MAX, 1'b0, 1'b1, Q_MAX, 1'b1);
        plan_eval(Q_MIN, 1'b1, 1'b1, Q_MAX, 1'b0);
        plan_write(6'd0, Q_MIN, Q_MIN, Q_MIN, 32'h0, 32'h0);
        plan_eval(Q_MAX, 1'b0, 1'b1, Q_MIN, 1'b1);
        plan_cfg(7'd4);
        for (int i = 0; i < 4; i++)
            plan_write(6'(i), 32'(2 * i * ONE), 32'(i * ONE), Q_ONE, 32'hFFFF_8000,
                       32'h0000_4000);
        plan_eval(-32'sd65536, 1'b0, 1'b0, '0, 1'b0);
        plan_eval(32'(3 * ONE), 1'b0, 1'b0, '0, 1'b0);
        plan_eval(32'(5 * ONE), 1'b0, 1'b0, '0, 1'b0);
        plan_eval(32'(7 * ONE), 1'b0, 1'b0, '0, 1'b0);
        plan_eval(Q_ONE, 1'b1, 1'b0, '0, 1'b0);
        plan_cfg(7'd0);
        plan_eval(32'(3 * ONE), 1'b0, 1'b0, '0, 1'b0);
        plan_write(6'd1, 32'h0, 32'h0001_8000, Q_MIN, Q_MAX, 32'hFFFF_FFFF);
        plan_eval(32'(5 * ONE), 1'b1, 1'b0, '0, 1'b0);
        plan_write(6'd63, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_drained();
                write_knot_count(plan[i].kc);
            end else begin
                send_word(plan[i].op, plan[i].idx, plan[i].knot, plan[i].ca, plan[i].cb,
                          plan[i].cc, plan[i].cd, plan[i].x, plan[i].last, plan[i].pin,
                          plan[i].res);
            end
        end

        foreach (kc_plan[p]) begin
            wait_drained();
            idle_pct = idle_plan[p % 3];
            write_knot_count(kc_plan[p]);
            load_table(eff_knots(kc_plan[p]));
            random_words();
        end

        wait_drained();
        $display("Covered %0d knot-count settings and %0d table writes;", cfg_writes,
                 writes_seen);
        $display("checked %0d evaluation results, %0d of them saturated.", evals_checked,
                 sat_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
